// ----- rtl/ldcs_pkg.sv -----
// shared constants, types and register codes for the led driver chain serializer
package ldcs_pkg;

    localparam int CHAIN_LENGTH    = 4;
    localparam int WORD_BITS       = 16;
    localparam int BIT_W           = 4;
    localparam int TOTAL_BITS      = CHAIN_LENGTH * WORD_BITS;
    localparam int TOTAL_W         = $clog2(TOTAL_BITS);
    localparam int WORD_IDX_W      = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
    localparam int CHIP_W          = 3;
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = 1;
    localparam int QCNT_W          = 2;

    localparam logic [7:0] REG_NOOP        = 8'h00;
    localparam logic [7:0] REG_INTENSITY   = 8'h0A;
    localparam logic [7:0] REG_SHUTDOWN    = 8'h0C;
    localparam logic [7:0] REG_TEST        = 8'h0F;
    localparam logic [7:0] INTENSITY_LIMIT = 8'd16;

    typedef struct packed {
        logic [WORD_IDX_W-1:0] target_word;
        logic [WORD_BITS-1:0]  value;
    } frame_entry_t;

endpackage

// ----- rtl/ldcs_front.sv -----
// front stage: accepts register writes, drops invalid ones, builds frame entries
module ldcs_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ldcs_pkg::CHIP_W-1:0]  chip_index,
    input  logic [7:0]                   reg_addr,
    input  logic [7:0]                   data_byte,
    output logic                         ent_valid,
    input  logic                         ent_ready,
    output ldcs_pkg::frame_entry_t       ent
);

    logic                   ent_valid_reg;
    logic                   ent_valid_next;
    ldcs_pkg::frame_entry_t ent_reg;
    ldcs_pkg::frame_entry_t ent_next;
    logic                   accept;
    logic                   in_chain;
    logic                   allowed;

    assign in_ready = !ent_valid_reg || ent_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        in_chain = ({1'b0, chip_index} < 4'(ldcs_pkg::CHAIN_LENGTH));
        allowed  = 1'b1;
        if ((reg_addr == ldcs_pkg::REG_SHUTDOWN || reg_addr == ldcs_pkg::REG_TEST)
            && data_byte > 8'd1)
        begin
            allowed = 1'b0;
        end
        if (reg_addr == ldcs_pkg::REG_INTENSITY && data_byte >= ldcs_pkg::INTENSITY_LIMIT)
        begin
            allowed = 1'b0;
        end
    end

    always_comb
    begin
        ent_valid_next = ent_valid_reg && !ent_ready;
        ent_next       = ent_reg;
        if (accept)
        begin
            ent_valid_next       = in_chain && allowed;
            ent_next.target_word = ldcs_pkg::WORD_IDX_W'(
                4'(ldcs_pkg::CHAIN_LENGTH - 1) - {1'b0, chip_index});
            ent_next.value       = {reg_addr, data_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent_valid = ent_valid_reg;
    assign ent       = ent_reg;

endmodule

// ----- rtl/ldcs_queue.sv -----
// two-entry queue between the front and back stages
module ldcs_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push_valid,
    output logic                   push_ready,
    input  ldcs_pkg::frame_entry_t push_ent,
    output logic                   pop_valid,
    input  logic                   pop_ready,
    output ldcs_pkg::frame_entry_t pop_ent
);

    ldcs_pkg::frame_entry_t          mem_reg [ldcs_pkg::QUEUE_DEPTH];
    logic [ldcs_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ldcs_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [ldcs_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ldcs_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [ldcs_pkg::QCNT_W-1:0]     count_reg;
    logic [ldcs_pkg::QCNT_W-1:0]     count_next;
    logic                            do_push;
    logic                            do_pop;

    assign push_ready = (count_reg != ldcs_pkg::QCNT_W'(ldcs_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_ent    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

// ----- rtl/ldcs_back.sv -----
// back stage: shifts each frame entry out one bit per beat
module ldcs_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   ent_valid,
    output logic                   ent_ready,
    input  ldcs_pkg::frame_entry_t ent,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   bit_value,
    output logic                   frame_start,
    output logic                   last
);

    localparam logic [ldcs_pkg::TOTAL_W-1:0] LAST_CNT =
        ldcs_pkg::TOTAL_W'(ldcs_pkg::TOTAL_BITS - 1);

    logic                            busy_reg;
    logic                            busy_next;
    logic [ldcs_pkg::TOTAL_W-1:0]    cnt_reg;
    logic [ldcs_pkg::TOTAL_W-1:0]    cnt_next;
    ldcs_pkg::frame_entry_t          cur_reg;
    ldcs_pkg::frame_entry_t          cur_next;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic                            bit_reg;
    logic                            bit_next;
    logic                            start_reg;
    logic                            start_next;
    logic                            last_reg;
    logic                            last_next;
    logic                            advance;
    logic                            emit;
    ldcs_pkg::frame_entry_t          sel;
    logic [ldcs_pkg::TOTAL_W-1:0]    sel_cnt;
    logic [ldcs_pkg::WORD_IDX_W-1:0] sel_word;
    logic [ldcs_pkg::BIT_W-1:0]      sel_bit;

    assign advance   = !out_valid_reg || out_ready;
    assign emit      = advance && (busy_reg || ent_valid);
    assign ent_ready = advance && !busy_reg;

    always_comb
    begin
        sel      = busy_reg ? cur_reg : ent;
        sel_cnt  = busy_reg ? cnt_reg : '0;
        sel_word = ldcs_pkg::WORD_IDX_W'(sel_cnt >> ldcs_pkg::BIT_W);
        sel_bit  = 4'(ldcs_pkg::WORD_BITS - 1) - sel_cnt[ldcs_pkg::BIT_W-1:0];

        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && !out_ready;
        bit_next       = bit_reg;
        start_next     = start_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            bit_next       = (sel_word == sel.target_word) ? sel.value[sel_bit] : 1'b0;
            start_next     = (sel_cnt == '0);
            last_next      = (sel_cnt == LAST_CNT);
            busy_next      = (sel_cnt != LAST_CNT);
            cnt_next       = sel_cnt + 1'b1;
            cur_next       = sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        bit_reg   <= bit_next;
        start_reg <= start_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign bit_value   = bit_reg;
    assign frame_start = start_reg;
    assign last        = last_reg;

endmodule

// ----- rtl/led_driver_chain_serializer.sv -----
// top level of the led driver chain serializer
//
// channel   dir  tdata fields (low bit up)                      tlast
// s_axis    in   chip_index[2:0] reg_addr[10:3] data_byte[18:11] -
// m_axis    out  bit_value[0] frame_start[1]                    last
//
// a valid write gives CHAIN_LENGTH*16 beats, one per cycle unless m_axis_tready stalls,
// set by the back bit counter; frames go back to back; a dropped write gives no beats
// reset clears the queue, the counter and the output valid
// the two-entry queue lets writes be taken while a frame is still shifting out
module led_driver_chain_serializer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // chip_index, reg_addr, data_byte, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // bit_value, frame_start, zero pad
    output logic        m_axis_tlast
);

    logic                   fq_valid;
    logic                   fq_ready;
    ldcs_pkg::frame_entry_t fq_ent;
    logic                   qb_valid;
    logic                   qb_ready;
    ldcs_pkg::frame_entry_t qb_ent;
    logic                   bit_value;
    logic                   frame_start;

    ldcs_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .chip_index (s_axis_tdata[2:0]),
        .reg_addr   (s_axis_tdata[10:3]),
        .data_byte  (s_axis_tdata[18:11]),
        .ent_valid  (fq_valid),
        .ent_ready  (fq_ready),
        .ent        (fq_ent)
    );

    ldcs_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_ent   (fq_ent),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_ent    (qb_ent)
    );

    ldcs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ent_valid   (qb_valid),
        .ent_ready   (qb_ready),
        .ent         (qb_ent),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .bit_value   (bit_value),
        .frame_start (frame_start),
        .last        (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, frame_start, bit_value};

endmodule
